FILE: rtl/core/tmwo_pkg.sv
// Shared types, codes and defaults for the tile map with write overlay.
package tmwo_pkg;

    localparam int COORD_W = 8;
    localparam int TILE_W  = 8;

    localparam int DEF_MAP_COLS  = 64;
    localparam int DEF_MAP_ROWS  = 64;
    localparam int DEF_OVL_DEPTH = 16;

    // request codes
    localparam logic [2:0] REQ_READ       = 3'd0;
    localparam logic [2:0] REQ_OVL_WRITE  = 3'd1;
    localparam logic [2:0] REQ_BASE_WRITE = 3'd2;
    localparam logic [2:0] REQ_FILL       = 3'd3;
    localparam logic [2:0] REQ_CLEAR      = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [TILE_W-1:0]  tile_value;
    } t_req;

    typedef struct packed {
        logic [TILE_W-1:0] tile_out;
        logic              from_overlay;
        logic [1:0]        status;
    } t_rsp;

    // control to the overlay: lookup loads the match vector, wr_en/clear commit
    typedef struct packed {
        logic               lookup;
        logic               wr_en;
        logic               clear;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TILE_W-1:0]  tile;
    } t_ovl_cmd;

    typedef struct packed {
        logic              hit;
        logic              full;
        logic [TILE_W-1:0] tile;
    } t_ovl_stat;

endpackage

FILE: rtl/core/tmwo_if.sv
// Valid/ready channel interfaces for request and response words.
interface tmwo_req_if;
    logic              valid;
    logic              ready;
    tmwo_pkg::t_req    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmwo_rsp_if;
    logic              valid;
    logic              ready;
    tmwo_pkg::t_rsp    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/tmwo_base_ram.sv
// Base tile memory: one write port, one registered read port.
module tmwo_base_ram #(
    parameter int CELLS  = tmwo_pkg::DEF_MAP_COLS * tmwo_pkg::DEF_MAP_ROWS,
    parameter int ADDR_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [tmwo_pkg::TILE_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [tmwo_pkg::TILE_W-1:0] o_rdata
);

    logic [tmwo_pkg::TILE_W-1:0] r_mem [CELLS];
    logic [tmwo_pkg::TILE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tmwo_overlay.sv
// Associative overlay: parallel coordinate match, update in place or append.
module tmwo_overlay #(
    parameter int DEPTH = tmwo_pkg::DEF_OVL_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmwo_pkg::t_ovl_cmd   i_cmd,
    output tmwo_pkg::t_ovl_stat  o_stat
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [tmwo_pkg::COORD_W-1:0] r_x    [DEPTH];
    logic [tmwo_pkg::COORD_W-1:0] r_y    [DEPTH];
    logic [tmwo_pkg::TILE_W-1:0]  r_tile [DEPTH];
    logic [CNT_W-1:0]             r_count, n_count;
    logic [DEPTH-1:0]             r_match, n_match;
    logic                         hit;
    logic                         full;
    logic                         append;
    logic [tmwo_pkg::TILE_W-1:0]  hit_tile;

    // only entries below the count take part in the match
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_match[i] = (CNT_W'(i) < r_count) && (r_x[i] == i_cmd.x) &&
                         (r_y[i] == i_cmd.y);
        end
    end

    assign hit    = |r_match;
    assign full   = (r_count == CNT_W'(DEPTH));
    assign append = i_cmd.wr_en && !hit && !full;

    // coordinates are unique, so at most one match bit is set
    always_comb begin
        hit_tile = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_match[i]) begin
                hit_tile = hit_tile | r_tile[i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (append) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_match <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.lookup) begin
                r_match <= n_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_cmd.wr_en && (r_match[i] || (append && r_count == CNT_W'(i)))) begin
                r_tile[i] <= i_cmd.tile;
                if (!r_match[i]) begin
                    r_x[i] <= i_cmd.x;
                    r_y[i] <= i_cmd.y;
                end
            end
        end
    end

    assign o_stat = '{hit: hit, full: full, tile: hit_tile};

endmodule

FILE: rtl/core/tile_map_with_write_overlay_unit.sv
// Top level: tile map with associative write overlay, control and output register.
//
// Usage
//   i_req carries request words (req_type, x_pos, y_pos, tile_value); o_rsp
//   returns one response word (tile_out, from_overlay, status) per request.
//   Both are valid/ready channels; a word moves when valid and ready are high.
// Timing
//   A request is taken in the idle state. On that edge the base RAM is read
//   and the overlay match vector is registered; in the lookup state that
//   follows, once the response register is free, the result is formed,
//   writes are committed and the response register is loaded. A fill
//   walks the base RAM one cell per cycle, then answers from the final state.
// Stall
//   The response register holds a finished word while the receiver stalls;
//   the next request is still taken. If that one finishes while the register
//   is still full, it waits in the lookup or final state until the register drains.
// Reset
//   Synchronous, active low. Clears the state machine, the output valid and
//   the overlay count. Base RAM contents are undefined until written.
module tile_map_with_write_overlay_unit #(
    parameter int MAP_COLS  = tmwo_pkg::DEF_MAP_COLS,
    parameter int MAP_ROWS  = tmwo_pkg::DEF_MAP_ROWS,
    parameter int OVL_DEPTH = tmwo_pkg::DEF_OVL_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmwo_req_if.sink   i_req,
    tmwo_rsp_if.source o_rsp
);

    localparam int CELLS  = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_FILL = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    tmwo_pkg::t_req              r_req;
    logic                        r_in_map;
    logic [ADDR_W-1:0]           r_addr;
    logic [ADDR_W-1:0]           r_fill_addr, n_fill_addr;
    logic                        r_out_valid, n_out_valid;
    tmwo_pkg::t_rsp              r_out, n_out;

    logic                        accept;
    logic                        out_free;
    logic                        load_out;
    logic                        in_map;
    logic [15:0]                 lin_addr;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [tmwo_pkg::TILE_W-1:0] ram_wdata;
    logic [tmwo_pkg::TILE_W-1:0] ram_rdata;
    tmwo_pkg::t_ovl_cmd          ovl_cmd;
    tmwo_pkg::t_ovl_stat         ovl_stat;

    // ---- input side ----
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign in_map = ({1'b0, i_req.data.x_pos} < 9'(MAP_COLS)) &&
                    ({1'b0, i_req.data.y_pos} < 9'(MAP_ROWS));
    // row-major cell index: y*MAP_COLS + x, fits 16 bits for maps up to 256 columns
    assign lin_addr = 16'(i_req.data.y_pos) * 16'(MAP_COLS) +
                      16'(i_req.data.x_pos);

    // response register frees up this cycle if the receiver takes the word
    assign out_free = !r_out_valid || o_rsp.ready;

    // ---- overlay control ----
    always_comb begin
        ovl_cmd        = '0;
        ovl_cmd.lookup = accept;
        ovl_cmd.x      = accept ? i_req.data.x_pos : r_req.x_pos;
        ovl_cmd.y      = accept ? i_req.data.y_pos : r_req.y_pos;
        ovl_cmd.tile   = r_req.tile_value;
        if (r_state == S_LOOK && out_free) begin
            ovl_cmd.wr_en = (r_req.req_type == tmwo_pkg::REQ_OVL_WRITE) && r_in_map;
            ovl_cmd.clear = (r_req.req_type == tmwo_pkg::REQ_CLEAR);
        end
    end

    // ---- base RAM write port: base write on commit, or fill sweep ----
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_req.tile_value;
        if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_fill_addr;
        end else if (r_state == S_LOOK && out_free &&
                     r_req.req_type == tmwo_pkg::REQ_BASE_WRITE && r_in_map) begin
            ram_we = 1'b1;
        end
    end

    // ---- sequencer and result formation ----
    always_comb begin
        n_state     = r_state;
        n_fill_addr = r_fill_addr;
        load_out    = 1'b0;
        n_out       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    case (r_req.req_type)
                        tmwo_pkg::REQ_READ: begin
                            if (!r_in_map) begin
                                n_out.status = tmwo_pkg::ST_RANGE;
                            end else if (ovl_stat.hit) begin
                                n_out.tile_out     = ovl_stat.tile;
                                n_out.from_overlay = 1'b1;
                            end else begin
                                n_out.tile_out = ram_rdata;
                            end
                        end
                        tmwo_pkg::REQ_OVL_WRITE: begin
                            if (!r_in_map) begin
                                n_out.status = tmwo_pkg::ST_RANGE;
                            end else if (!ovl_stat.hit && ovl_stat.full) begin
                                n_out.status = tmwo_pkg::ST_FULL;
                            end
                        end
                        tmwo_pkg::REQ_BASE_WRITE: begin
                            if (!r_in_map) begin
                                n_out.status = tmwo_pkg::ST_RANGE;
                            end
                        end
                        tmwo_pkg::REQ_FILL: begin
                            // sweep first, respond afterwards
                            load_out    = 1'b0;
                            n_state     = S_FILL;
                            n_fill_addr = '0;
                        end
                        default: begin
                            // clear and unknown codes answer all zero
                        end
                    endcase
                end
            end
            S_FILL: begin
                n_fill_addr = r_fill_addr + ADDR_W'(1);
                if (r_fill_addr == LAST_ADDR) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req.data;
            r_in_map <= in_map;
            r_addr   <= lin_addr[ADDR_W-1:0];
        end
        r_fill_addr <= n_fill_addr;
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // ---- storage ----
    tmwo_base_ram #(
        .CELLS  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept && in_map),
        .i_raddr (lin_addr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    tmwo_overlay #(
        .DEPTH (OVL_DEPTH)
    ) u_overlay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ovl_cmd),
        .o_stat  (ovl_stat)
    );

    // ---- checks ----
    // base RAM is written only by the sweep or by an in-range base write commit
    a_ram_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_FILL) ||
                   (r_state == S_LOOK && r_req.req_type == tmwo_pkg::REQ_BASE_WRITE &&
                    r_in_map))
        else $error("base RAM written outside fill or base write");

    // overlay commits only when the result is loaded into the response register
    a_ovl_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ovl_cmd.wr_en || ovl_cmd.clear) |-> (r_state == S_LOOK) && load_out)
        else $error("overlay committed without a response");

    // a taken request moves to the lookup state on the next cycle
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOK) && !i_req.ready)
        else $error("accepted request did not move to lookup");

    // the sweep ends right after the last cell
    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && r_fill_addr == LAST_ADDR) |=> (r_state == S_FIN))
        else $error("fill sweep did not finish at last cell");

endmodule

FILE: test/tile_map_with_write_overlay_unit_tb.sv
// Testbench for the tile map with write overlay: directed table, random episodes, scoreboard.
module tile_map_with_write_overlay_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = tmwo_pkg::DEF_MAP_COLS;
    localparam int ROWS  = tmwo_pkg::DEF_MAP_ROWS;
    localparam int DEPTH = tmwo_pkg::DEF_OVL_DEPTH;
    localparam int CELLS = COLS * ROWS;

    // request codes the block does not know; it answers them with an all-zero word
    localparam logic [2:0] REQ_BAD_LO = 3'd5;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;

    localparam int RANDOM_WORDS     = 320;
    localparam int MAX_RANDOM_FILLS = 6;     // a fill sweeps every base cell
    localparam int DRAIN_CYCLES     = 32;
    localparam int CYCLE_LIMIT      = 400_000;
    localparam int REPORT_LIMIT     = 10;

    // canned answers for the directed table
    localparam tmwo_pkg::t_rsp RSP_ZERO  = '{8'h00, 1'b0, tmwo_pkg::ST_OK};
    localparam tmwo_pkg::t_rsp RSP_RANGE = '{8'h00, 1'b0, tmwo_pkg::ST_RANGE};
    localparam tmwo_pkg::t_rsp RSP_FULL  = '{8'h00, 1'b0, tmwo_pkg::ST_FULL};

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_PATTERN, RX_HEAVY} t_rx_mode;

    // One table row. A row with reps > 1 is sent reps times with x and tile
    // stepping up by one each time. typed rows carry their answer, the rest
    // are checked against the predictor.
    typedef struct packed {
        logic [2:0]     op;
        logic [7:0]     x;
        logic [7:0]     y;
        logic [7:0]     tile;
        logic [4:0]     reps;
        logic           typed;
        tmwo_pkg::t_rsp want;
    } t_dir_row;

    localparam int N_DIRECTED = 26;
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        // range checks on every request that looks at coordinates
        '{tmwo_pkg::REQ_READ,       8'd64,  8'd0,   8'h00, 5'd1,  1'b1, RSP_RANGE},
        '{tmwo_pkg::REQ_READ,       8'd0,   8'd64,  8'h00, 5'd1,  1'b1, RSP_RANGE},
        '{tmwo_pkg::REQ_READ,       8'd255, 8'd255, 8'hFF, 5'd1,  1'b1, RSP_RANGE},
        '{tmwo_pkg::REQ_OVL_WRITE,  8'd255, 8'd0,   8'h05, 5'd1,  1'b1, RSP_RANGE},
        '{tmwo_pkg::REQ_BASE_WRITE, 8'd0,   8'd255, 8'h09, 5'd1,  1'b1, RSP_RANGE},
        // unknown request codes change nothing
        '{REQ_BAD_LO,               8'd128, 8'd128, 8'h55, 5'd1,  1'b1, RSP_ZERO},
        '{REQ_BAD_HI,               8'd255, 8'd255, 8'hFF, 5'd1,  1'b1, RSP_ZERO},
        // overlay hit before the base has ever been written
        '{tmwo_pkg::REQ_OVL_WRITE,  8'd10,  8'd10,  8'hAA, 5'd1,  1'b1, RSP_ZERO},
        '{tmwo_pkg::REQ_READ,       8'd10,  8'd10,  8'h00, 5'd1,  1'b1,
          '{8'hAA, 1'b1, tmwo_pkg::ST_OK}},
        // fill ignores its coordinates; afterwards every base cell is defined
        '{tmwo_pkg::REQ_FILL,       8'd200, 8'd200, 8'hFF, 5'd1,  1'b1, RSP_ZERO},
        '{tmwo_pkg::REQ_READ,       8'd0,   8'd0,   8'h00, 5'd1,  1'b1,
          '{8'hFF, 1'b0, tmwo_pkg::ST_OK}},
        '{tmwo_pkg::REQ_BASE_WRITE, 8'd63,  8'd0,   8'h00, 5'd1,  1'b1, RSP_ZERO},
        '{tmwo_pkg::REQ_READ,       8'd63,  8'd0,   8'hFF, 5'd1,  1'b1,
          '{8'h00, 1'b0, tmwo_pkg::ST_OK}},
        '{tmwo_pkg::REQ_BASE_WRITE, 8'd0,   8'd63,  8'h81, 5'd1,  1'b1, RSP_ZERO},
        '{tmwo_pkg::REQ_READ,       8'd0,   8'd63,  8'h00, 5'd1,  1'b1,
          '{8'h81, 1'b0, tmwo_pkg::ST_OK}},
        // update in place, then clear
        '{tmwo_pkg::REQ_OVL_WRITE,  8'd10,  8'd10,  8'h00, 5'd1,  1'b1, RSP_ZERO},
        '{tmwo_pkg::REQ_READ,       8'd10,  8'd10,  8'hFF, 5'd1,  1'b1,
          '{8'h00, 1'b1, tmwo_pkg::ST_OK}},
        '{tmwo_pkg::REQ_CLEAR,      8'd33,  8'd44,  8'h12, 5'd1,  1'b1, RSP_ZERO},
        '{tmwo_pkg::REQ_READ,       8'd10,  8'd10,  8'h00, 5'd1,  1'b1,
          '{8'hFF, 1'b0, tmwo_pkg::ST_OK}},
        // fill the overlay, overflow it, then update an entry while full
        '{tmwo_pkg::REQ_OVL_WRITE,  8'd0,   8'd5,   8'h30, 5'd16, 1'b1, RSP_ZERO},
        '{tmwo_pkg::REQ_OVL_WRITE,  8'd20,  8'd5,   8'h11, 5'd1,  1'b1, RSP_FULL},
        '{tmwo_pkg::REQ_OVL_WRITE,  8'd3,   8'd5,   8'h7E, 5'd1,  1'b1, RSP_ZERO},
        '{tmwo_pkg::REQ_READ,       8'd3,   8'd5,   8'h00, 5'd1,  1'b1,
          '{8'h7E, 1'b1, tmwo_pkg::ST_OK}},
        '{tmwo_pkg::REQ_READ,       8'd0,   8'd5,   8'h00, 5'd16, 1'b0, RSP_ZERO},
        '{tmwo_pkg::REQ_READ,       8'd20,  8'd5,   8'h00, 5'd1,  1'b1,
          '{8'hFF, 1'b0, tmwo_pkg::ST_OK}},
        '{tmwo_pkg::REQ_CLEAR,      8'd0,   8'd0,   8'h00, 5'd1,  1'b1, RSP_ZERO}
    };

    logic i_clk;
    logic i_rst_n;

    tmwo_req_if req_if ();
    tmwo_rsp_if rsp_if ();

    tile_map_with_write_overlay_unit #(
        .MAP_COLS  (COLS),
        .MAP_ROWS  (ROWS),
        .OVL_DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // ------------------------------------------------------------------
    // Predictor state: base map plus the patch list kept in append order
    // ------------------------------------------------------------------
    logic [tmwo_pkg::TILE_W-1:0]  base_mem   [CELLS];
    logic [tmwo_pkg::COORD_W-1:0] patch_x    [DEPTH];
    logic [tmwo_pkg::COORD_W-1:0] patch_y    [DEPTH];
    logic [tmwo_pkg::TILE_W-1:0]  patch_tile [DEPTH];
    int                           patch_count;

    tmwo_pkg::t_rsp expected_answers [$];
    int             mismatches;
    int             cycle_count;

    // random episode shape: a small window of cells so that patches collide
    int   pool_x0, pool_y0, pool_w, pool_h;
    int   fills_left;
    int   burst_left;
    bit   sender_idles;

    // Index of the patch at (x, y), or -1. Coordinates stay unique, so the
    // first hit from entry 0 up is the only one.
    function automatic int find_patch(input logic [tmwo_pkg::COORD_W-1:0] x,
                                      input logic [tmwo_pkg::COORD_W-1:0] y);
        for (int i = 0; i < patch_count; i++) begin
            if (patch_x[i] == x && patch_y[i] == y) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the predictor state and returns its answer word.
    function automatic tmwo_pkg::t_rsp apply_tile_request(input tmwo_pkg::t_req r);
        tmwo_pkg::t_rsp res;
        int             hit;
        bit             on_map;
        res    = '0;
        on_map = (int'(r.x_pos) < COLS) && (int'(r.y_pos) < ROWS);
        hit    = find_patch(r.x_pos, r.y_pos);
        case (r.req_type)
            tmwo_pkg::REQ_READ: begin
                if (!on_map) begin
                    res.status = tmwo_pkg::ST_RANGE;
                end else if (hit >= 0) begin
                    res.tile_out     = patch_tile[hit];
                    res.from_overlay = 1'b1;
                end else begin
                    res.tile_out = base_mem[int'(r.y_pos) * COLS + int'(r.x_pos)];
                end
            end
            tmwo_pkg::REQ_OVL_WRITE: begin
                if (!on_map) begin
                    res.status = tmwo_pkg::ST_RANGE;
                end else if (hit >= 0) begin
                    patch_tile[hit] = r.tile_value;
                end else if (patch_count < DEPTH) begin
                    patch_x[patch_count]    = r.x_pos;
                    patch_y[patch_count]    = r.y_pos;
                    patch_tile[patch_count] = r.tile_value;
                    patch_count++;
                end else begin
                    res.status = tmwo_pkg::ST_FULL;
                end
            end
            tmwo_pkg::REQ_BASE_WRITE: begin
                if (!on_map) begin
                    res.status = tmwo_pkg::ST_RANGE;
                end else begin
                    base_mem[int'(r.y_pos) * COLS + int'(r.x_pos)] = r.tile_value;
                end
            end
            tmwo_pkg::REQ_FILL: begin
                foreach (base_mem[i]) begin
                    base_mem[i] = r.tile_value;
                end
            end
            tmwo_pkg::REQ_CLEAR: begin
                patch_count = 0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Random request, mostly inside the current window. The directed table
    // fills the base before any random word, so every in-range read is defined.
    function automatic tmwo_pkg::t_req random_request();
        tmwo_pkg::t_req r;
        int             roll;
        r.tile_value = 8'($urandom_range(0, 255));
        r.x_pos      = 8'(pool_x0 + int'($urandom_range(0, pool_w - 1)));
        r.y_pos      = 8'(pool_y0 + int'($urandom_range(0, pool_h - 1)));
        roll         = int'($urandom_range(0, 99));
        if (roll < 2 && fills_left > 0) begin
            r.req_type = tmwo_pkg::REQ_FILL;
            fills_left--;
        end else if (roll < 36) begin
            r.req_type = tmwo_pkg::REQ_OVL_WRITE;
        end else if (roll < 70) begin
            r.req_type = tmwo_pkg::REQ_READ;
        end else if (roll < 80) begin
            r.req_type = tmwo_pkg::REQ_BASE_WRITE;
        end else if (roll < 85) begin
            // anywhere on the map, mostly base hits
            r.req_type = tmwo_pkg::REQ_READ;
            r.x_pos    = 8'($urandom_range(0, COLS - 1));
            r.y_pos    = 8'($urandom_range(0, ROWS - 1));
        end else if (roll < 93) begin
            // off the map on one axis or both
            case ($urandom_range(0, 2))
                0:       r.req_type = tmwo_pkg::REQ_READ;
                1:       r.req_type = tmwo_pkg::REQ_OVL_WRITE;
                default: r.req_type = tmwo_pkg::REQ_BASE_WRITE;
            endcase
            if ($urandom_range(0, 1) == 0) begin
                r.x_pos = 8'($urandom_range(COLS, 255));
                r.y_pos = 8'($urandom_range(0, 255));
            end else begin
                r.x_pos = 8'($urandom_range(0, 255));
                r.y_pos = 8'($urandom_range(ROWS, 255));
            end
        end else if (roll < 96) begin
            r.req_type = tmwo_pkg::REQ_CLEAR;
        end else begin
            r.req_type = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        end
        return r;
    endfunction

    // Sends one request word in bursts with random gaps, then records the
    // answer the block owes for it.
    task automatic send_request(input tmwo_pkg::t_req r, input bit typed,
                                input tmwo_pkg::t_rsp want);
        tmwo_pkg::t_rsp predicted;
        if (burst_left == 0) begin
            burst_left = int'($urandom_range(1, 16));
            if (sender_idles && $urandom_range(0, 2) != 0) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        // state always follows the predictor, typed rows only pin the answer
        predicted = apply_tile_request(r);
        expected_answers.insert(expected_answers.size(), typed ? want : predicted);
    endtask

    // ------------------------------------------------------------------
    // Clock, 2 ns period
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random episodes, drain
    // ------------------------------------------------------------------
    initial begin
        tmwo_pkg::t_req r;
        int             words_sent;
        int             episode_len;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        patch_count  = 0;
        burst_left   = 0;
        sender_idles = 1'b1;
        fills_left   = MAX_RANDOM_FILLS;
        pool_x0      = 0;
        pool_y0      = 0;
        pool_w       = 1;
        pool_h       = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[n]) begin
            for (int k = 0; k < int'(DIRECTED[n].reps); k++) begin
                r.req_type   = DIRECTED[n].op;
                r.x_pos      = 8'(int'(DIRECTED[n].x) + k);
                r.y_pos      = DIRECTED[n].y;
                r.tile_value = 8'(int'(DIRECTED[n].tile) + k);
                send_request(r, DIRECTED[n].typed, DIRECTED[n].want);
            end
        end

        // Each episode hammers one window; windows up to 40 cells overflow
        // the overlay now and then. Most episodes end with a clear.
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            pool_w       = int'($urandom_range(1, 8));
            pool_h       = int'($urandom_range(1, 5));
            pool_x0      = int'($urandom_range(0, COLS - pool_w));
            pool_y0      = int'($urandom_range(0, ROWS - pool_h));
            sender_idles = ($urandom_range(0, 3) != 0);
            episode_len  = int'($urandom_range(15, 50));
            repeat (episode_len) begin
                r = random_request();
                if (r.req_type <= tmwo_pkg::REQ_CLEAR) begin
                    words_sent++;
                end
                send_request(r, 1'b0, RSP_ZERO);
            end
            if ($urandom_range(0, 9) < 6) begin
                r.req_type   = tmwo_pkg::REQ_CLEAR;
                r.x_pos      = 8'($urandom_range(0, 255));
                r.y_pos      = 8'($urandom_range(0, 255));
                r.tile_value = 8'($urandom_range(0, 255));
                send_request(r, 1'b0, RSP_ZERO);
                words_sent++;
            end
        end
        req_if.valid <= 1'b0;

        // wait out every owed answer, then keep watching for strays
        while (expected_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a mode that is picked again at random
    // ------------------------------------------------------------------
    initial begin
        t_rx_mode   mode;
        int         left;
        logic [7:0] pat;
        rsp_if.ready = 1'b0;
        mode         = RX_OPEN;
        left         = 0;
        pat          = 8'h5A;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                left = int'($urandom_range(16, 96));
                pat  = 8'($urandom_range(1, 255));
            end
            left--;
            pat = {pat[6:0], pat[7]};
            case (mode)
                RX_OPEN:    rsp_if.ready <= 1'b1;
                RX_LIGHT:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: rsp_if.ready <= pat[0];
                default:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Answer checker: each word against the oldest owed answer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_answers
        tmwo_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: answer word with none owed: tile %02h ovl %0b st %0d",
                             $realtime, rsp_if.data.tile_out, rsp_if.data.from_overlay,
                             rsp_if.data.status);
                end
            end else begin
                want = expected_answers.pop_front();
                if (rsp_if.data.tile_out     !== want.tile_out ||
                    rsp_if.data.from_overlay !== want.from_overlay ||
                    rsp_if.data.status       !== want.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: answer mismatch: tile %02h/%02h ovl %0b/%0b st %0d/%0d",
                                 $realtime, want.tile_out, rsp_if.data.tile_out,
                                 want.from_overlay, rsp_if.data.from_overlay,
                                 want.status, rsp_if.data.status);
                    end
                end
            end
        end
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        mismatches  = 0;
        cycle_count = 0;
    end

endmodule
